// File: hw/rtl/khdc_pkg.sv
// Shared types and constants of the keypad hex/decimal converter.
package khdc_pkg;

   typedef enum logic [1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_ERROR = 2'd1,
      FAULT_OVER  = 2'd2
   } fault_type;

   typedef logic [3:0] nibble_type;
   typedef logic [4:0] sym_type;

   // Index 0 is the leftmost digit.
   typedef struct packed {
      nibble_type [3:0] digit;
      logic [1:0]       column;
      logic [2:0]       key_count;
      logic             first_seen;
      fault_type        fault;
   } state_type;

   localparam logic [2:0]  KEYS_FULL    = 3'd4;
   localparam logic [15:0] HEX_DEC_MAX  = 16'h270F;
   localparam nibble_type  DEC_DIGIT_MAX = 4'd9;

   localparam sym_type SYM_U    = 5'd16;
   localparam sym_type SYM_DASH = 5'd17;

   // Fixed display patterns, element 0 is the leftmost symbol.
   localparam logic [3:0][4:0] ERR_PATTERN  = {5'd0, SYM_DASH, SYM_DASH, 5'd14};
   localparam logic [3:0][4:0] OVER_PATTERN = {SYM_DASH, 5'd14, SYM_U, 5'd0};

endpackage

// File: hw/rtl/khdc_step.sv
// Next-state logic for one event: column scan, key entry and radix conversion.
module khdc_step (
   input  khdc_pkg::state_type cur,
   input  logic                mode,
   input  logic [3:0]          rows_pressed,
   input  logic                side_pressed,
   output khdc_pkg::state_type nxt
);

   logic [15:0] hex_val;
   logic [13:0] v14;
   logic [29:0] prod10;
   logic [29:0] prod100;
   logic [29:0] prod1000;
   logic [9:0]  q10;
   logic [6:0]  q100;
   logic [3:0]  q1000;
   logic [13:0] rem10;
   logic [9:0]  rem100;
   logic [6:0]  rem1000;
   khdc_pkg::nibble_type [3:0] dec_digits;

   logic [13:0] dec_val;
   logic        any_above_nine;
   khdc_pkg::nibble_type [3:0] hex_digits;

   // Hex to decimal: constant divisors through reciprocal multiplies, exact below 10240
   assign hex_val  = {cur.digit[0], cur.digit[1], cur.digit[2], cur.digit[3]};
   assign v14      = hex_val[13:0];
   assign prod10   = 30'(v14) * 30'd52429;
   assign prod100  = 30'(v14) * 30'd5243;
   assign prod1000 = 30'(v14) * 30'd8389;
   assign q10      = prod10[28:19];
   assign q100     = prod100[25:19];
   assign q1000    = prod1000[26:23];
   assign rem10    = v14 - 14'(q10) * 14'd10;
   assign rem100   = q10 - 10'(q100) * 10'd10;
   assign rem1000  = q100 - 7'(q1000) * 7'd10;

   assign dec_digits[0] = q1000;
   assign dec_digits[1] = rem1000[3:0];
   assign dec_digits[2] = rem100[3:0];
   assign dec_digits[3] = rem10[3:0];

   // Decimal to hex
   assign dec_val = 14'(cur.digit[0]) * 14'd1000 + 14'(cur.digit[1]) * 14'd100
                  + 14'(cur.digit[2]) * 14'd10 + 14'(cur.digit[3]);
   assign any_above_nine = (cur.digit[0] > khdc_pkg::DEC_DIGIT_MAX)
                        || (cur.digit[1] > khdc_pkg::DEC_DIGIT_MAX)
                        || (cur.digit[2] > khdc_pkg::DEC_DIGIT_MAX)
                        || (cur.digit[3] > khdc_pkg::DEC_DIGIT_MAX);
   assign hex_digits[0] = {2'b00, dec_val[13:12]};
   assign hex_digits[1] = dec_val[11:8];
   assign hex_digits[2] = dec_val[7:4];
   assign hex_digits[3] = dec_val[3:0];

   always_comb begin
      nxt = cur;
      if (!mode) begin
         nxt.column = cur.column + 2'd1;
      end else if (cur.fault == khdc_pkg::FAULT_NONE) begin
         if (cur.key_count >= khdc_pkg::KEYS_FULL) begin
            if (rows_pressed[3:1] != 3'b000) begin
               nxt.fault = khdc_pkg::FAULT_ERROR;
            end else if (rows_pressed[0]) begin
               // Both conversions in one event leave the entered digits as they are, unless the hex value is over range
               if (hex_val > khdc_pkg::HEX_DEC_MAX) begin
                  nxt.fault = khdc_pkg::FAULT_OVER;
               end else if (!side_pressed) begin
                  nxt.digit = dec_digits;
               end
            end else if (side_pressed) begin
               if (any_above_nine) begin
                  nxt.fault = khdc_pkg::FAULT_OVER;
               end else begin
                  nxt.digit = hex_digits;
               end
            end
         end else begin
            for (int r = 0; r < 4; r++) begin
               if (rows_pressed[r] && (nxt.key_count < khdc_pkg::KEYS_FULL)) begin
                  if (cur.first_seen) begin
                     nxt.digit[0] = nxt.digit[1];
                     nxt.digit[1] = nxt.digit[2];
                     nxt.digit[2] = nxt.digit[3];
                  end
                  nxt.digit[3]   = {cur.column, 2'(r)};
                  nxt.first_seen = 1'b1;
                  nxt.key_count  = nxt.key_count + 3'd1;
               end
            end
         end
      end
   end

endmodule

// File: hw/rtl/keypad_hex_decimal_converter.sv
// Keypad hex/decimal converter: an event enters an input register, the next
// state and the display are worked out in one pass and land in the result
// register, so every event gives one result, and a new event is taken every
// cycle while the result side keeps up. A scan tick (tuser 0) steps the
// column; a button event (tuser 1) enters keys as 4*column+row until four
// are in, then row 0 converts hex to decimal and the side button decimal to
// hex. Errors and overflows stick until reset.
module keypad_hex_decimal_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rows_pressed[3:0], side_pressed[4], zero pad
   input  logic [0:0]  req_tuser,   // mode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // digit_high[4:0], digit_mid_high[9:5],
                                    // digit_mid_low[14:10], digit_low[19:15],
                                    // status[21:20], converting[22],
                                    // scan_column[24:23], zero pad
);

   logic                in_valid_ff;
   logic                mode_ff;
   logic [3:0]          rows_ff;
   logic                side_ff;
   logic                rsp_valid_ff;
   logic [24:0]         rsp_data_ff;
   logic [24:0]         rsp_data_in;
   khdc_pkg::state_type state_ff;
   khdc_pkg::state_type state_in;
   khdc_pkg::sym_type [3:0] sym;
   logic                advance;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   khdc_step u_step (
      .cur          (state_ff),
      .mode         (mode_ff),
      .rows_pressed (rows_ff),
      .side_pressed (side_ff),
      .nxt          (state_in)
   );

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         case (state_in.fault)
            khdc_pkg::FAULT_ERROR: sym[i] = khdc_pkg::ERR_PATTERN[i];
            khdc_pkg::FAULT_OVER:  sym[i] = khdc_pkg::OVER_PATTERN[i];
            default:               sym[i] = {1'b0, state_in.digit[i]};
         endcase
      end
      rsp_data_in = {state_in.column,
                     state_in.key_count >= khdc_pkg::KEYS_FULL,
                     state_in.fault,
                     sym[3], sym[2], sym[1], sym[0]};
   end

   // Input register: hold the event until the result stage takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         mode_ff <= req_tuser[0];
         rows_ff <= req_tdata[3:0];
         side_ff <= req_tdata[4];
      end
   end

   // State and result register advance together
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_data_ff};

endmodule
